[src/scroll_layer_transparent_copy_unit_macros.svh]
// Assertion macros shared by the scrolling layer copy unit.
`ifndef SCROLL_LAYER_TRANSPARENT_COPY_UNIT_MACROS_SVH
`define SCROLL_LAYER_TRANSPARENT_COPY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Flag any clock edge at which the condition holds.
`define SLTC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
// Flag any clock edge at which the antecedent holds and the consequent does not.
`define SLTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SLTC_ASSERT_NEVER(label, clk, rst, cond, msg)
`define SLTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif
`endif

[src/sltc_pkg.sv]
// Types, constants and helpers shared by the scrolling layer copy unit.
`timescale 1ns / 1ps
`default_nettype none
package sltc_pkg;
   localparam int COORD_W    = 9;
   localparam int DIM_W      = 10;
   localparam int SCROLL_W   = 16;
   localparam int SUM_W      = 17;
   localparam int MAG_W      = 16;
   localparam int LIN_W      = 18;
   localparam int PIX_W      = 16;
   localparam int PRI_W      = 8;
   localparam int TV_W       = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [DIM_W-1:0] DIM_MAX = 10'd512;

   // remainder pipeline: bits of the dividend retired per stage
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = MAG_W / DIV_BITS_PER_STAGE;

   // queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_LAYER_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER_HEIGHT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_X          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_Y          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_MASK        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSPARENT_VALUE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PRIORITY_ENABLE   = 3'd6;

   typedef struct packed {
      logic [DIM_W-1:0]    width_eff;
      logic [DIM_W-1:0]    height_eff;
      logic [SCROLL_W-1:0] scroll_x;
      logic [SCROLL_W-1:0] scroll_y;
      logic [PIX_W-1:0]    pixel_mask;
      logic [TV_W-1:0]     transparent_value;
      logic                priority_enable;
   } cfg_type;

   typedef struct packed {
      logic             mode;
      logic             active;
      logic [LIN_W-1:0] lin_addr;
      logic [PIX_W-1:0] load_pixel;
      logic [PRI_W-1:0] load_priority;
   } op_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (v > DIM_MAX) begin
         return DIM_MAX;
      end else begin
         return v;
      end
   endfunction
endpackage
`default_nettype wire

[src/sltc_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sltc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      read_data_ff <= mem_ff[addr];
   end

   assign read_data = read_data_ff;
endmodule
`default_nettype wire

[src/sltc_wrap.sv]
// Pipelined floor-modulo of a signed coordinate sum by the layer dimension.
`timescale 1ns / 1ps
`default_nettype none
module sltc_wrap (
   input  logic                         clock,
   input  logic                         in_neg,
   input  logic [sltc_pkg::MAG_W-1:0]   in_mag,
   input  logic [sltc_pkg::DIM_W-1:0]   modulus,
   output logic [sltc_pkg::COORD_W-1:0] out_pos
);
   import sltc_pkg::*;

   logic [DIM_W-1:0]   rem_ff  [DIV_STAGES];
   logic [MAG_W-1:0]   bits_ff [DIV_STAGES];
   logic               neg_ff  [DIV_STAGES];
   logic [DIM_W-1:0]   rem_last;
   logic [DIM_W-1:0]   pos_in;
   logic [COORD_W-1:0] pos_ff;

   // one restoring step: shift in a dividend bit, subtract if it fits
   function automatic logic [DIM_W-1:0] rem_step(input logic [DIM_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [DIM_W-1:0] m);
      logic [DIM_W:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[DIM_W-1:0];
   endfunction

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [DIM_W-1:0] rem_prev;
      logic [MAG_W-1:0] bits_prev;
      logic             neg_prev;
      logic [DIM_W-1:0] rem_in;
      logic [MAG_W-1:0] bits_in;

      if (g == 0) begin : g_head
         assign rem_prev  = '0;
         assign bits_prev = in_mag;
         assign neg_prev  = in_neg;
      end else begin : g_body
         assign rem_prev  = rem_ff[g-1];
         assign bits_prev = bits_ff[g-1];
         assign neg_prev  = neg_ff[g-1];
      end

      always_comb begin
         rem_in  = rem_prev;
         bits_in = bits_prev;
         for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            rem_in  = rem_step(rem_in, bits_in[MAG_W-1], modulus);
            bits_in = {bits_in[MAG_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         bits_ff[g] <= bits_in;
         neg_ff[g]  <= neg_prev;
      end
   end

   // a negative sum with a remainder folds back from the top
   assign rem_last = rem_ff[DIV_STAGES-1];
   assign pos_in   = (neg_ff[DIV_STAGES-1] && rem_last != '0) ? (modulus - rem_last)
                                                               : rem_last;

   always_ff @(posedge clock) begin
      pos_ff <= pos_in[COORD_W-1:0];
   end

   assign out_pos = pos_ff;
endmodule
`default_nettype wire

[src/sltc_front.sv]
// Front end: accepts items, wraps coordinates and forms the layer address.
`timescale 1ns / 1ps
`default_nettype none
module sltc_front #(
   parameter int LAYER_PIXELS = 262144
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sltc_pkg::cfg_type            cfg,
   input  logic                         accept,
   input  logic                         req_mode,
   input  logic [sltc_pkg::COORD_W-1:0] req_pos_x,
   input  logic [sltc_pkg::COORD_W-1:0] req_pos_y,
   input  logic [sltc_pkg::PIX_W-1:0]   req_load_pixel,
   input  logic [sltc_pkg::PRI_W-1:0]   req_load_priority,
   output logic                         out_valid,
   output sltc_pkg::op_type             out_op
);
   import sltc_pkg::*;

   localparam int WRAP_LAT = DIV_STAGES + 1;
   localparam int PROD_W   = COORD_W + DIM_W;

   typedef struct packed {
      logic             mode;
      logic             load_ok;
      logic [PIX_W-1:0] load_pixel;
      logic [PRI_W-1:0] load_priority;
   } side_type;

   logic [SUM_W-1:0]   sum_x, sum_y;
   logic [SUM_W-1:0]   abs_x, abs_y;
   side_type           side_in;
   logic               s0_valid_ff;
   side_type           s0_side_ff;
   logic               neg_x_ff, neg_y_ff;
   logic [MAG_W-1:0]   mag_x_ff, mag_y_ff;
   logic [COORD_W-1:0] pos_x, pos_y;
   logic               valid_ff [WRAP_LAT];
   side_type           side_ff  [WRAP_LAT];
   logic               mul_valid_ff;
   side_type           mul_side_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [LIN_W-1:0]   prod_ff;
   logic [COORD_W-1:0] x_ff;
   logic [LIN_W-1:0]   lin_in;
   logic               in_range;
   logic               out_valid_ff;
   op_type             out_op_ff;

   // render adds the sign-extended scroll; load takes the coordinate as is
   always_comb begin
      if (req_mode == MODE_RENDER) begin
         sum_x = {{(SUM_W-COORD_W){1'b0}}, req_pos_x} + {cfg.scroll_x[SCROLL_W-1], cfg.scroll_x};
         sum_y = {{(SUM_W-COORD_W){1'b0}}, req_pos_y} + {cfg.scroll_y[SCROLL_W-1], cfg.scroll_y};
      end else begin
         sum_x = {{(SUM_W-COORD_W){1'b0}}, req_pos_x};
         sum_y = {{(SUM_W-COORD_W){1'b0}}, req_pos_y};
      end
      abs_x = sum_x[SUM_W-1] ? (~sum_x + SUM_W'(1)) : sum_x;
      abs_y = sum_y[SUM_W-1] ? (~sum_y + SUM_W'(1)) : sum_y;

      side_in.mode          = req_mode;
      side_in.load_ok       = ({1'b0, req_pos_x} < cfg.width_eff)
                           && ({1'b0, req_pos_y} < cfg.height_eff);
      side_in.load_pixel    = req_load_pixel;
      side_in.load_priority = req_load_priority;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      s0_side_ff <= side_in;
      neg_x_ff   <= sum_x[SUM_W-1];
      neg_y_ff   <= sum_y[SUM_W-1];
      mag_x_ff   <= abs_x[MAG_W-1:0];
      mag_y_ff   <= abs_y[MAG_W-1:0];
   end

   sltc_wrap u_wrap_x (
      .clock   (clock),
      .in_neg  (neg_x_ff),
      .in_mag  (mag_x_ff),
      .modulus (cfg.width_eff),
      .out_pos (pos_x)
   );

   sltc_wrap u_wrap_y (
      .clock   (clock),
      .in_neg  (neg_y_ff),
      .in_mag  (mag_y_ff),
      .modulus (cfg.height_eff),
      .out_pos (pos_y)
   );

   // side data rides alongside the remainder pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WRAP_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= s0_valid_ff;
         for (int i = 1; i < WRAP_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
      side_ff[0] <= s0_side_ff;
      for (int i = 1; i < WRAP_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign prod_in = {{DIM_W{1'b0}}, pos_y} * {{COORD_W{1'b0}}, cfg.width_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= valid_ff[WRAP_LAT-1];
      end
      mul_side_ff <= side_ff[WRAP_LAT-1];
      prod_ff     <= prod_in[LIN_W-1:0];
      x_ff        <= pos_x;
   end

   assign lin_in   = prod_ff + {{(LIN_W-COORD_W){1'b0}}, x_ff};
   assign in_range = {{(32-LIN_W){1'b0}}, lin_in} < 32'(LAYER_PIXELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mul_valid_ff;
      end
      out_op_ff.mode          <= mul_side_ff.mode;
      out_op_ff.active        <= in_range
                                 && (mul_side_ff.mode == MODE_RENDER || mul_side_ff.load_ok);
      out_op_ff.lin_addr      <= lin_in;
      out_op_ff.load_pixel    <= mul_side_ff.load_pixel;
      out_op_ff.load_priority <= mul_side_ff.load_priority;
   end

   assign out_valid = out_valid_ff;
   assign out_op    = out_op_ff;
endmodule
`default_nettype wire

[src/sltc_fifo.sv]
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module sltc_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sltc_pkg::op_type push_op,
   input  logic             pop,
   output sltc_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);
   import sltc_pkg::*;

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0]    count_ff, count_in;
   logic                   do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CREDIT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CREDIT_W'(1);
         2'b01:   count_in = count_ff - CREDIT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op = entry_ff[rd_ptr_ff];
endmodule
`default_nettype wire

[src/sltc_back.sv]
// Back end: layer stores, load writes, render reads and transparency test.
`timescale 1ns / 1ps
`default_nettype none
module sltc_back #(
   parameter int LAYER_PIXELS = 262144,
   parameter int PIXEL_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sltc_pkg::cfg_type          cfg,
   input  logic                       in_valid,
   input  sltc_pkg::op_type           in_op,
   output logic                       in_pop,
   output logic                       rsp_valid,
   output logic [sltc_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic [sltc_pkg::PRI_W-1:0] rsp_priority_out,
   output logic                       rsp_pixel_write,
   output logic                       rsp_priority_write
);
   import sltc_pkg::*;

   localparam int ADDR_W = $clog2(LAYER_PIXELS);

   logic                  store_we;
   logic [ADDR_W-1:0]     store_addr;
   logic [PIXEL_BITS-1:0] rd_pixel;
   logic [PRI_W-1:0]      rd_priority;
   logic                  rd_valid_ff;
   logic                  rd_active_ff;
   logic [PIX_W-1:0]      pixel;
   logic [PRI_W-1:0]      priority_val;
   logic                  transparent;
   logic                  write_flag;
   logic                  rsp_valid_ff;
   logic [PIX_W-1:0]      pixel_ff;
   logic [PRI_W-1:0]      priority_ff;
   logic                  pixel_write_ff;
   logic                  priority_write_ff;

   // take one item every cycle the queue offers one
   assign in_pop     = in_valid;
   assign store_we   = in_valid && in_op.mode == MODE_LOAD && in_op.active;
   assign store_addr = ADDR_W'(in_op.lin_addr);

   sltc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (LAYER_PIXELS)
   ) u_pixel_store (
      .clock      (clock),
      .write_en   (store_we),
      .addr       (store_addr),
      .write_data (in_op.load_pixel[PIXEL_BITS-1:0]),
      .read_data  (rd_pixel)
   );

   sltc_ram #(
      .WIDTH (PRI_W),
      .DEPTH (LAYER_PIXELS)
   ) u_priority_store (
      .clock      (clock),
      .write_en   (store_we),
      .addr       (store_addr),
      .write_data (in_op.load_priority),
      .read_data  (rd_priority)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= in_valid && in_op.mode == MODE_RENDER;
      end
      rd_active_ff <= in_op.active;
   end

   // beyond the store the pixel and priority read as zero
   assign pixel        = rd_active_ff ? PIX_W'(rd_pixel) : '0;
   assign priority_val = rd_active_ff ? rd_priority : '0;
   assign transparent  = !cfg.transparent_value[TV_W-1]
                      && ((pixel & cfg.pixel_mask) == cfg.transparent_value[PIX_W-1:0]);
   assign write_flag   = !transparent;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rd_valid_ff;
      end
      pixel_ff          <= pixel;
      priority_ff       <= cfg.priority_enable ? priority_val : '0;
      pixel_write_ff    <= write_flag;
      priority_write_ff <= cfg.priority_enable && write_flag;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_out      = pixel_ff;
   assign rsp_priority_out   = priority_ff;
   assign rsp_pixel_write    = pixel_write_ff;
   assign rsp_priority_write = priority_write_ff;
endmodule
`default_nettype wire

[src/scroll_layer_transparent_copy_unit.sv]
// Top level of the scrolling layer transparent copy unit.
`timescale 1ns / 1ps
`default_nettype none
`include "scroll_layer_transparent_copy_unit_macros.svh"
// Usage:
//  Items enter on start while busy is low. An item with req_mode at load writes
//  req_load_pixel and req_load_priority at layer position (req_pos_x, req_pos_y)
//  and gives no result; a load outside the layer is dropped. An item with
//  req_mode at render reads the layer at the screen position plus the scroll,
//  wrapped into the layer, and gives one result.
//  Each result shows on the rsp_ ports for a single cycle with rsp_valid high;
//  the receiver cannot hold it off, so nothing inside ever waits on it.
//  Throughput: one item per clock while busy is low, loads and renders mixed
//  freely. A render result passes through the remainder pipelines (two dividend
//  bits per stage) that wrap x and y, the multiply-add forming the address, the
//  queue between front and back, and the registered read of the layer stores.
//  busy rises only when every queue credit is taken, which a back end draining
//  one item per cycle does not allow in practice.
//  The csr_ port writes registers at any edge with csr_write_enable high; write
//  them only while no item is in flight.
//  Reset: registers return to their defaults, the queue empties. The layer stores
//  are not cleared; reading a position never loaded gives an arbitrary pixel.
module scroll_layer_transparent_copy_unit #(
   parameter int LAYER_PIXELS = 262144,
   parameter int PIXEL_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [sltc_pkg::COORD_W-1:0]    req_pos_x,
   input  logic [sltc_pkg::COORD_W-1:0]    req_pos_y,
   input  logic [sltc_pkg::PIX_W-1:0]      req_load_pixel,
   input  logic [sltc_pkg::PRI_W-1:0]      req_load_priority,
   output logic                            rsp_valid,
   output logic [sltc_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic [sltc_pkg::PRI_W-1:0]      rsp_priority_out,
   output logic                            rsp_pixel_write,
   output logic                            rsp_priority_write,
   input  logic                            csr_write_enable,
   input  logic [sltc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sltc_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import sltc_pkg::*;

   // configuration registers, held raw as written
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [SCROLL_W-1:0] scroll_x_ff, scroll_x_in;
   logic [SCROLL_W-1:0] scroll_y_ff, scroll_y_in;
   logic [PIX_W-1:0]    mask_ff, mask_in;
   logic [TV_W-1:0]     tv_ff, tv_in;
   logic                prio_en_ff, prio_en_in;
   cfg_type             cfg;

   logic                accept;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                front_valid;
   op_type              front_op;
   op_type              head_op;
   logic                q_empty;
   logic                q_full;
   logic                q_pop;

   // decode one register write per edge
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      scroll_x_in = scroll_x_ff;
      scroll_y_in = scroll_y_ff;
      mask_in     = mask_ff;
      tv_in       = tv_ff;
      prio_en_in  = prio_en_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_LAYER_WIDTH:       width_in    = csr_write_data[DIM_W-1:0];
            REG_LAYER_HEIGHT:      height_in   = csr_write_data[DIM_W-1:0];
            REG_SCROLL_X:          scroll_x_in = csr_write_data[SCROLL_W-1:0];
            REG_SCROLL_Y:          scroll_y_in = csr_write_data[SCROLL_W-1:0];
            REG_PIXEL_MASK:        mask_in     = csr_write_data[PIX_W-1:0];
            REG_TRANSPARENT_VALUE: tv_in       = csr_write_data[TV_W-1:0];
            REG_PRIORITY_ENABLE:   prio_en_in  = csr_write_data[0];
            default:               ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_MAX;
         height_ff   <= DIM_MAX;
         scroll_x_ff <= '0;
         scroll_y_ff <= '0;
         mask_ff     <= '1;
         tv_ff       <= '1;
         prio_en_ff  <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         scroll_x_ff <= scroll_x_in;
         scroll_y_ff <= scroll_y_in;
         mask_ff     <= mask_in;
         tv_ff       <= tv_in;
         prio_en_ff  <= prio_en_in;
      end
   end

   // clamp the layer dimensions into their usable range once, here
   always_comb begin
      cfg.width_eff         = eff_dim(width_ff);
      cfg.height_eff        = eff_dim(height_ff);
      cfg.scroll_x          = scroll_x_ff;
      cfg.scroll_y          = scroll_y_ff;
      cfg.pixel_mask        = mask_ff;
      cfg.transparent_value = tv_ff;
      cfg.priority_enable   = prio_en_ff;
   end

   // Credits: one per item between the accept edge and the pop from the queue.
   // Capping them at the queue depth keeps the queue from ever overflowing.
   assign busy   = (credit_ff == CREDIT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      case ({accept, q_pop})
         2'b10:   credit_in = credit_ff + CREDIT_W'(1);
         2'b01:   credit_in = credit_ff - CREDIT_W'(1);
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   sltc_front #(
      .LAYER_PIXELS (LAYER_PIXELS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .accept            (accept),
      .req_mode          (req_mode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_load_pixel    (req_load_pixel),
      .req_load_priority (req_load_priority),
      .out_valid         (front_valid),
      .out_op            (front_op)
   );

   sltc_fifo u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .push_op (front_op),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   sltc_back #(
      .LAYER_PIXELS (LAYER_PIXELS),
      .PIXEL_BITS   (PIXEL_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .in_valid           (!q_empty),
      .in_op              (head_op),
      .in_pop             (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_pixel_out      (rsp_pixel_out),
      .rsp_priority_out   (rsp_priority_out),
      .rsp_pixel_write    (rsp_pixel_write),
      .rsp_priority_write (rsp_priority_write)
   );

   // the credit limit must keep the queue from being pushed while full
   `SLTC_ASSERT_NEVER(a_queue_no_overflow, clock, reset, front_valid && q_full, "queue pushed while full")
   // every queued item still holds a credit
   `SLTC_ASSERT_IMPLY(a_credit_covers_queue, clock, reset, credit_ff == '0, q_empty, "queue holds an item with no credit")
   // a priority write never goes out without its pixel write
   `SLTC_ASSERT_IMPLY(a_prio_needs_pixel, clock, reset, rsp_valid && rsp_priority_write, rsp_pixel_write, "priority written without pixel")
endmodule
`default_nettype wire
